>>> hw/rtl/slprp_pkg.sv
// ----------------------------------------------------------------------------
// slprp_pkg
// Shared constants, codes and types of the strong Lucas probable-prime test.
// ----------------------------------------------------------------------------
package slprp_pkg;

  localparam int N_BITS_DEF  = 64;
  localparam int CAND_W      = 64;
  localparam int D_W         = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int RED_STEPS   = 32;
  localparam int RED_CNT_W   = $clog2(RED_STEPS);

  localparam logic [D_W-1:0] D_START     = 32'd5;
  localparam logic [D_W-1:0] D_ABS_LIMIT = 32'h7FFF_FFFD;

  typedef enum logic [1:0] {
    KIND_COMPOSITE,
    KIND_PRIME,
    KIND_ODD
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } q_ctl_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQRT,
    B_GCD,
    B_JAC,
    B_RED,
    B_SETUP,
    B_CHAIN,
    B_CHECK,
    B_DONE
  } back_state_t;

  typedef enum logic [3:0] {
    OP_U2,
    OP_V2,
    OP_QQ,
    OP_T1,
    OP_T2,
    OP_T3,
    OP_T4A,
    OP_T4,
    OP_QKD,
    OP_VR,
    OP_QR
  } op_t;

endpackage

>>> hw/rtl/strong_lucas_probable_prime_test.sv
// ----------------------------------------------------------------------------
// strong_lucas_probable_prime_test
// Strong Lucas probable-prime test with Selfridge discriminant selection.
// ----------------------------------------------------------------------------
// One candidate is taken per beat and gives one verdict beat. Values below
// two, two itself and even values go straight to the verdict. Other candidates
// go through an integer square root, then for each discriminant tried a binary
// gcd and a binary Jacobi symbol, two reductions, and a Lucas chain in which
// every step costs three to nine modular products on the single shift-and-add
// multiplier. That multiplier dominates the run time. Two candidates can wait
// in the input queue while one is worked on.
module strong_lucas_probable_prime_test #(
  parameter int N_BITS = slprp_pkg::N_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // candidate [63:0]
  input  logic [slprp_pkg::CAND_W-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // probable_prime [0], chosen_d [32:1], zero [39:33]
  output logic [slprp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import slprp_pkg::*;

  q_ctl_t            q_ctl;
  logic [N_BITS-1:0] q_n;
  logic              q_ready;

  slprp_front #(.W(N_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ctl     (q_ctl),
    .q_n       (q_n),
    .q_ready   (q_ready)
  );

  slprp_back #(.W(N_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_ctl      (q_ctl),
    .q_n        (q_n),
    .q_ready    (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> hw/rtl/slprp_front.sv
// ----------------------------------------------------------------------------
// slprp_front
// Takes candidates, classifies the trivial cases and queues them for the back.
// ----------------------------------------------------------------------------
module slprp_front #(
  parameter int W = slprp_pkg::N_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [slprp_pkg::CAND_W-1:0] in_tdata,
  output slprp_pkg::q_ctl_t           q_ctl,
  output logic [W-1:0]                q_n,
  input  logic                        q_ready
);
  import slprp_pkg::*;

  logic [W-1:0] n_mem_r [2];
  kind_t        kind_mem_r [2];
  logic         wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic [W-1:0] n_in;
  kind_t        kind_in;
  logic         push, pop;

  assign n_in      = in_tdata[W-1:0];
  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign pop       = q_ctl.valid && q_ready;

  always_comb begin
    if (n_in < W'(2)) begin
      kind_in = KIND_COMPOSITE;
    end else if (n_in == W'(2)) begin
      kind_in = KIND_PRIME;
    end else if (!n_in[0]) begin
      kind_in = KIND_COMPOSITE;
    end else begin
      kind_in = KIND_ODD;
    end
  end

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
  end

  assign q_ctl.valid = (cnt_r != 2'd0);
  assign q_ctl.kind  = kind_mem_r[rp_r];
  assign q_n         = n_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      n_mem_r[wp_r]    <= n_in;
      kind_mem_r[wp_r] <= kind_in;
    end
  end

endmodule

>>> hw/rtl/slprp_mulmod.sv
// ----------------------------------------------------------------------------
// slprp_mulmod
// Shift-and-add modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module slprp_mulmod #(
  parameter int W = slprp_pkg::N_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] n,
  output logic         done,
  output logic [W-1:0] p
);
  localparam int CW = $clog2(W);

  logic [W-1:0]  acc_r, acc_nxt, a_r, b_r, b_nxt, n_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [W-1:0]  dbl, step;

  function automatic logic [W-1:0] add_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
    logic [W:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[W-1:0];
  endfunction

  assign dbl  = add_m(acc_r, acc_r, n_r);
  assign step = b_r[W-1] ? add_m(dbl, a_r, n_r) : dbl;

  always_comb begin
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      b_nxt    = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = step;
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      a_r <= a;
      n_r <= n;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

>>> hw/rtl/slprp_back.sv
// ----------------------------------------------------------------------------
// slprp_back
// Sequencer for the square check, the discriminant search and the Lucas chain.
// ----------------------------------------------------------------------------
module slprp_back #(
  parameter int W = slprp_pkg::N_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  slprp_pkg::q_ctl_t                 q_ctl,
  input  logic [W-1:0]                      q_n,
  output logic                              q_ready,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [slprp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import slprp_pkg::*;

  localparam int HW = (W + 1) / 2;
  localparam int JW = (W > D_W) ? W : D_W;
  localparam int SW = $clog2(W + 1);

  back_state_t state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic        mwait_r, mwait_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_prime_r, out_prime_nxt;
  logic [D_W-1:0] out_d_r, out_d_nxt;
  logic        res_prime_r, res_prime_nxt;
  logic [D_W-1:0] res_d_r, res_d_nxt;

  logic [W-1:0]     n_r, n_nxt;
  logic [2*HW-1:0]  sq_x_r, sq_x_nxt;
  logic [HW+1:0]    sq_rem_r, sq_rem_nxt;
  logic [HW-1:0]    sq_root_r, sq_root_nxt;
  logic [RED_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [D_W-1:0]   dabs_r, dabs_nxt;
  logic             dneg_r, dneg_nxt;
  logic [JW-1:0]    ga_r, ga_nxt, gb_r, gb_nxt;
  logic [JW-1:0]    ja_r, ja_nxt, jn_r, jn_nxt;
  logic             jneg_r, jneg_nxt;
  logic [W-1:0]     red_rem_r, red_rem_nxt;
  logic [D_W-1:0]   red_mag_r, red_mag_nxt;
  logic             red_neg_r, red_neg_nxt, red_ph_r, red_ph_nxt;
  logic [W:0]       dd_r, dd_nxt;
  logic [SW-1:0]    s_r, s_nxt, r_r, r_nxt;
  logic [W-1:0]     dm_r, dm_nxt, qm_r, qm_nxt, q2m_r, q2m_nxt;
  logic [W-1:0]     u_r, u_nxt, v_r, v_nxt, u2m_r, u2m_nxt, v2m_r, v2m_nxt;
  logic [W-1:0]     qkd_r, qkd_nxt, q2kd_r, q2kd_nxt;
  logic [W-1:0]     t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt, t4_r, t4_nxt;

  logic [HW+2:0]  sq_cat, sq_trial, sq_diff;
  logic           sq_ge;
  logic [W:0]     red_cat, red_diff;
  logic [W-1:0]   red_step, red_fin;
  logic [D_W-1:0] dabs_p2, d_val;
  logic           mul_start, mul_done;
  logic [W-1:0]   mul_a, mul_b, mul_p, v_new;

  function automatic logic [W-1:0] add_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
    logic [W:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
    return x - y + ((x >= y) ? '0 : m);
  endfunction

  function automatic logic [W-1:0] half_m(input logic [W-1:0] x, input logic [W-1:0] m);
    return x[0] ? ((x >> 1) + (m >> 1) + W'(1)) : (x >> 1);
  endfunction

  slprp_mulmod #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .n     (n_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign q_ready  = (state_r == B_IDLE);
  assign sq_cat   = {sq_rem_r[HW:0], sq_x_r[2*HW-1 -: 2]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign sq_ge    = (sq_cat >= sq_trial);
  assign sq_diff  = sq_cat - sq_trial;
  assign red_cat  = {red_rem_r, red_mag_r[D_W-1]};
  assign red_diff = red_cat - {1'b0, n_r};
  assign red_step = (red_cat >= {1'b0, n_r}) ? red_diff[W-1:0] : red_cat[W-1:0];
  assign red_fin  = (red_neg_r && red_step != '0) ? (n_r - red_step) : red_step;
  assign dabs_p2  = dabs_r + D_W'(2);
  assign d_val    = dneg_r ? (~dabs_r + D_W'(1)) : dabs_r;
  assign v_new    = sub_m(mul_p, q2kd_r, n_r);

  always_comb begin
    case (op_r)
      OP_U2:   begin mul_a = u2m_r; mul_b = v2m_r; end
      OP_V2:   begin mul_a = v2m_r; mul_b = v2m_r; end
      OP_QQ:   begin mul_a = qm_r;  mul_b = qm_r;  end
      OP_T1:   begin mul_a = u2m_r; mul_b = v_r;   end
      OP_T2:   begin mul_a = u_r;   mul_b = v2m_r; end
      OP_T3:   begin mul_a = v2m_r; mul_b = v_r;   end
      OP_T4A:  begin mul_a = u2m_r; mul_b = u_r;   end
      OP_T4:   begin mul_a = t4_r;  mul_b = dm_r;  end
      OP_QKD:  begin mul_a = qkd_r; mul_b = qm_r;  end
      OP_VR:   begin mul_a = v_r;   mul_b = v_r;   end
      OP_QR:   begin mul_a = qkd_r; mul_b = qkd_r; end
      default: begin mul_a = '0;    mul_b = '0;    end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    mwait_nxt     = mwait_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_prime_nxt = out_prime_r;
    out_d_nxt     = out_d_r;
    res_prime_nxt = res_prime_r;
    res_d_nxt     = res_d_r;
    n_nxt         = n_r;
    sq_x_nxt      = sq_x_r;
    sq_rem_nxt    = sq_rem_r;
    sq_root_nxt   = sq_root_r;
    cnt_nxt       = cnt_r;
    dabs_nxt      = dabs_r;
    dneg_nxt      = dneg_r;
    ga_nxt        = ga_r;
    gb_nxt        = gb_r;
    ja_nxt        = ja_r;
    jn_nxt        = jn_r;
    jneg_nxt      = jneg_r;
    red_rem_nxt   = red_rem_r;
    red_mag_nxt   = red_mag_r;
    red_neg_nxt   = red_neg_r;
    red_ph_nxt    = red_ph_r;
    dd_nxt        = dd_r;
    s_nxt         = s_r;
    r_nxt         = r_r;
    dm_nxt        = dm_r;
    qm_nxt        = qm_r;
    q2m_nxt       = q2m_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    u2m_nxt       = u2m_r;
    v2m_nxt       = v2m_r;
    qkd_nxt       = qkd_r;
    q2kd_nxt      = q2kd_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    t3_nxt        = t3_r;
    t4_nxt        = t4_r;
    mul_start     = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (q_ctl.valid) begin
          n_nxt     = q_n;
          res_d_nxt = '0;
          case (q_ctl.kind)
            KIND_PRIME: begin
              res_prime_nxt = 1'b1;
              state_nxt     = B_DONE;
            end
            KIND_ODD: begin
              sq_x_nxt    = (2*HW)'(q_n);
              sq_rem_nxt  = '0;
              sq_root_nxt = '0;
              cnt_nxt     = '0;
              state_nxt   = B_SQRT;
            end
            default: begin
              res_prime_nxt = 1'b0;
              state_nxt     = B_DONE;
            end
          endcase
        end
      end

      B_SQRT: begin
        sq_x_nxt    = sq_x_r << 2;
        sq_rem_nxt  = sq_ge ? sq_diff[HW+1:0] : sq_cat[HW+1:0];
        sq_root_nxt = {sq_root_r[HW-2:0], sq_ge};
        cnt_nxt     = cnt_r + RED_CNT_W'(1);
        if (cnt_r == RED_CNT_W'(HW - 1)) begin
          if (sq_rem_nxt == '0) begin
            res_prime_nxt = 1'b0;
            state_nxt     = B_DONE;
          end else begin
            dabs_nxt  = D_START;
            dneg_nxt  = 1'b0;
            ga_nxt    = JW'(n_r);
            gb_nxt    = JW'(D_START);
            state_nxt = B_GCD;
          end
        end
      end

      B_GCD: begin
        if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (ga_r == gb_r) begin
          if (ga_r > JW'(1) && JW'(n_r) > ga_r) begin
            res_prime_nxt = 1'b0;
            res_d_nxt     = '0;
            state_nxt     = B_DONE;
          end else begin
            ja_nxt    = JW'(dabs_r);
            jn_nxt    = JW'(n_r);
            jneg_nxt  = dneg_r && (n_r[1:0] == 2'b11);
            state_nxt = B_JAC;
          end
        end else if (ga_r > gb_r) begin
          ga_nxt = ga_r - gb_r;
        end else begin
          gb_nxt = gb_r - ga_r;
        end
      end

      B_JAC: begin
        if (ja_r == '0) begin
          if (jn_r == JW'(1) && jneg_r) begin
            red_mag_nxt = dabs_r;
            red_neg_nxt = dneg_r;
            red_ph_nxt  = 1'b0;
            red_rem_nxt = '0;
            cnt_nxt     = '0;
            state_nxt   = B_RED;
          end else if (dabs_p2 > D_ABS_LIMIT) begin
            res_prime_nxt = 1'b0;
            res_d_nxt     = '0;
            state_nxt     = B_DONE;
          end else begin
            dabs_nxt  = dabs_p2;
            dneg_nxt  = !dneg_r;
            ga_nxt    = JW'(n_r);
            gb_nxt    = JW'(dabs_p2);
            state_nxt = B_GCD;
          end
        end else if (!ja_r[0]) begin
          ja_nxt = ja_r >> 1;
          if (jn_r[2:0] == 3'd3 || jn_r[2:0] == 3'd5) begin
            jneg_nxt = !jneg_r;
          end
        end else if (ja_r < jn_r) begin
          ja_nxt = jn_r;
          jn_nxt = ja_r;
          if (ja_r[1:0] == 2'b11 && jn_r[1:0] == 2'b11) begin
            jneg_nxt = !jneg_r;
          end
        end else begin
          ja_nxt = ja_r - jn_r;
        end
      end

      B_RED: begin
        red_rem_nxt = red_step;
        red_mag_nxt = red_mag_r << 1;
        cnt_nxt     = cnt_r + RED_CNT_W'(1);
        if (cnt_r == RED_CNT_W'(RED_STEPS - 1)) begin
          red_rem_nxt = '0;
          cnt_nxt     = '0;
          if (!red_ph_r) begin
            dm_nxt      = red_fin;
            red_mag_nxt = dneg_r ? ((dabs_r + D_W'(1)) >> 2) : ((dabs_r - D_W'(1)) >> 2);
            red_neg_nxt = !dneg_r;
            red_ph_nxt  = 1'b1;
          end else begin
            qm_nxt    = red_fin;
            dd_nxt    = {1'b0, n_r} + (W+1)'(1);
            s_nxt     = '0;
            state_nxt = B_SETUP;
          end
        end
      end

      B_SETUP: begin
        if (!dd_r[0]) begin
          dd_nxt = dd_r >> 1;
          s_nxt  = s_r + SW'(1);
        end else begin
          dd_nxt    = dd_r >> 1;
          u_nxt     = W'(1);
          v_nxt     = W'(1);
          u2m_nxt   = W'(1);
          v2m_nxt   = W'(1);
          q2m_nxt   = add_m(qm_r, qm_r, n_r);
          qkd_nxt   = qm_r;
          op_nxt    = OP_U2;
          mwait_nxt = 1'b0;
          state_nxt = ((dd_r >> 1) == '0) ? B_CHECK : B_CHAIN;
        end
      end

      B_CHAIN: begin
        if (!mwait_r) begin
          mul_start = 1'b1;
          mwait_nxt = 1'b1;
        end else if (mul_done) begin
          mwait_nxt = 1'b0;
          case (op_r)
            OP_U2: begin
              u2m_nxt = mul_p;
              op_nxt  = OP_V2;
            end
            OP_V2: begin
              v2m_nxt = sub_m(mul_p, q2m_r, n_r);
              op_nxt  = OP_QQ;
            end
            OP_QQ: begin
              qm_nxt  = mul_p;
              q2m_nxt = add_m(mul_p, mul_p, n_r);
              if (dd_r[0]) begin
                op_nxt = OP_T1;
              end else begin
                dd_nxt = dd_r >> 1;
                op_nxt = OP_U2;
                if ((dd_r >> 1) == '0) begin
                  state_nxt = B_CHECK;
                end
              end
            end
            OP_T1: begin
              t1_nxt = mul_p;
              op_nxt = OP_T2;
            end
            OP_T2: begin
              t2_nxt = mul_p;
              op_nxt = OP_T3;
            end
            OP_T3: begin
              t3_nxt = mul_p;
              op_nxt = OP_T4A;
            end
            OP_T4A: begin
              t4_nxt = mul_p;
              op_nxt = OP_T4;
            end
            OP_T4: begin
              t4_nxt = mul_p;
              u_nxt  = half_m(add_m(t1_r, t2_r, n_r), n_r);
              v_nxt  = half_m(add_m(t3_r, mul_p, n_r), n_r);
              op_nxt = OP_QKD;
            end
            OP_QKD: begin
              qkd_nxt = mul_p;
              dd_nxt  = dd_r >> 1;
              op_nxt  = OP_U2;
              if ((dd_r >> 1) == '0) begin
                state_nxt = B_CHECK;
              end
            end
            OP_VR: begin
              v_nxt = v_new;
              if (v_new == '0) begin
                res_prime_nxt = 1'b1;
                res_d_nxt     = d_val;
                state_nxt     = B_DONE;
              end else if ({1'b0, r_r} + (SW+1)'(1) < {1'b0, s_r}) begin
                op_nxt = OP_QR;
              end else begin
                res_prime_nxt = 1'b0;
                res_d_nxt     = d_val;
                state_nxt     = B_DONE;
              end
            end
            OP_QR: begin
              qkd_nxt  = mul_p;
              q2kd_nxt = add_m(mul_p, mul_p, n_r);
              r_nxt    = r_r + SW'(1);
              op_nxt   = OP_VR;
            end
            default: begin
              state_nxt = B_IDLE;
            end
          endcase
        end
      end

      B_CHECK: begin
        res_d_nxt = d_val;
        if (u_r == '0 || v_r == '0) begin
          res_prime_nxt = 1'b1;
          state_nxt     = B_DONE;
        end else if (s_r > SW'(1)) begin
          q2kd_nxt  = add_m(qkd_r, qkd_r, n_r);
          r_nxt     = SW'(1);
          op_nxt    = OP_VR;
          mwait_nxt = 1'b0;
          state_nxt = B_CHAIN;
        end else begin
          res_prime_nxt = 1'b0;
          state_nxt     = B_DONE;
        end
      end

      B_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_prime_r;
          out_d_nxt     = res_d_r;
          state_nxt     = B_IDLE;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      mwait_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mwait_r     <= mwait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    out_prime_r <= out_prime_nxt;
    out_d_r     <= out_d_nxt;
    res_prime_r <= res_prime_nxt;
    res_d_r     <= res_d_nxt;
    n_r         <= n_nxt;
    sq_x_r      <= sq_x_nxt;
    sq_rem_r    <= sq_rem_nxt;
    sq_root_r   <= sq_root_nxt;
    cnt_r       <= cnt_nxt;
    dabs_r      <= dabs_nxt;
    dneg_r      <= dneg_nxt;
    ga_r        <= ga_nxt;
    gb_r        <= gb_nxt;
    ja_r        <= ja_nxt;
    jn_r        <= jn_nxt;
    jneg_r      <= jneg_nxt;
    red_rem_r   <= red_rem_nxt;
    red_mag_r   <= red_mag_nxt;
    red_neg_r   <= red_neg_nxt;
    red_ph_r    <= red_ph_nxt;
    dd_r        <= dd_nxt;
    s_r         <= s_nxt;
    r_r         <= r_nxt;
    dm_r        <= dm_nxt;
    qm_r        <= qm_nxt;
    q2m_r       <= q2m_nxt;
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    u2m_r       <= u2m_nxt;
    v2m_r       <= v2m_nxt;
    qkd_r       <= qkd_nxt;
    q2kd_r      <= q2kd_nxt;
    t1_r        <= t1_nxt;
    t2_r        <= t2_nxt;
    t3_r        <= t3_nxt;
    t4_r        <= t4_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - D_W - 1)'(0), out_d_r, out_prime_r};

endmodule

>>> hw/rtl/slprp_checker.sv
// ----------------------------------------------------------------------------
// slprp_checker
// Port-level checks on the verdict channel of the prime test.
// ----------------------------------------------------------------------------
module slprp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [slprp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import slprp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict beat changed while stalled");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:D_W+1] == '0)
    else $error("padding bits of the verdict beat are not zero");

  a_dform: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[D_W:1] != '0 |-> out_tdata[2:1] == 2'b01)
    else $error("discriminant is not one modulo four");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("verdict valid straight after reset");

endmodule

bind strong_lucas_probable_prime_test slprp_checker u_chk (.*);

>>> bench/strong_lucas_probable_prime_test_tb.sv
// ----------------------------------------------------------------------------
// strong_lucas_probable_prime_test_tb
// Self-checking bench for the strong Lucas probable-prime test.
// ----------------------------------------------------------------------------
// Candidates are streamed in under random idling on both sides. A behavioural
// predictor computes each verdict and discriminant, and every output beat is
// compared with the oldest pending expectation.
// ----------------------------------------------------------------------------
module strong_lucas_probable_prime_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB         = slprp_pkg::N_BITS_DEF;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic               prime;
    logic signed [31:0] disc;
  } verdict_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [slprp_pkg::CAND_W-1:0]        in_tdata;
  logic                                out_tvalid;
  logic                                out_tready;
  logic [slprp_pkg::OUT_TDATA_W-1:0]   out_tdata;

  verdict_t verdicts_due[$];
  int       errors;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_cycles;
  int       quiet_cycles;

  strong_lucas_probable_prime_test #(.N_BITS(NB)) u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] mulm(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p % {64'd0, n});
  endfunction

  function automatic logic [63:0] addm(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [64:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, n}) t = t - {1'b0, n};
    return t[63:0];
  endfunction

  function automatic logic [63:0] subm(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    return (a >= b) ? a - b : a + (n - b);
  endfunction

  function automatic logic [63:0] halfm(logic [63:0] x, logic [63:0] n);
    return x[0] ? (x >> 1) + (n >> 1) + 64'd1 : x >> 1;
  endfunction

  function automatic logic [63:0] smod(longint v, logic [63:0] n);
    logic [63:0] r;
    if (v >= 0) return 64'(v) % n;
    r = 64'(-v) % n;
    return (r == 0) ? 64'd0 : n - r;
  endfunction

  function automatic bit perfect_square(logic [63:0] n);
    logic [63:0] lo, hi, mid;
    lo = 0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo * lo == n;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic int jacobi_sym(logic [63:0] a, logic [63:0] n);
    int res;
    logic [63:0] t;
    res = 1;
    a = a % n;
    while (a != 0) begin
      while (!a[0]) begin
        a = a >> 1;
        if (n[2:0] == 3'd3 || n[2:0] == 3'd5) res = -res;
      end
      t = a;
      a = n;
      n = t;
      if (a[1:0] == 2'd3 && n[1:0] == 2'd3) res = -res;
      a = a % n;
    end
    return (n == 1) ? res : 0;
  endfunction

  function automatic verdict_t lucas_verdict(logic [63:0] cand);
    logic [63:0] n, g, dd, dm, u, v, u2, v2, qm, q2m, qkd, q2kd, t1, t2, t3, t4;
    longint dabs, d, q;
    int sgn, s, dbits;
    n = (NB == 64) ? cand : cand & ((64'd1 << NB) - 1);
    if (n < 2) return '{1'b0, 32'sd0};
    if (n == 2) return '{1'b1, 32'sd0};
    if (!n[0] || perfect_square(n)) return '{1'b0, 32'sd0};
    dabs = 5;
    sgn = 1;
    forever begin
      d = sgn * dabs;
      sgn = -sgn;
      g = gcd64(n, 64'(dabs));
      if (g > 1 && n > g) return '{1'b0, 32'sd0};
      if (jacobi_sym(smod(d, n), n) == -1) break;
      dabs += 2;
      if (dabs > 64'h7FFF_FFFD) return '{1'b0, 32'sd0};
    end
    q = (1 - d) / 4;
    if (n == '1) begin
      s = 64;
      dd = 1;
    end else begin
      s = 0;
      dd = n + 1;
      while (!dd[0]) begin
        dd = dd >> 1;
        s++;
      end
    end
    dbits = 0;
    for (int i = 0; i < 64; i++) if (dd[i]) dbits = i + 1;
    dm = smod(d, n);
    u = 1; v = 1; u2 = 1; v2 = 1;
    qm = smod(q, n);
    q2m = addm(qm, qm, n);
    qkd = qm;
    for (int i = 1; i < dbits; i++) begin
      u2 = mulm(u2, v2, n);
      v2 = subm(mulm(v2, v2, n), q2m, n);
      qm = mulm(qm, qm, n);
      q2m = addm(qm, qm, n);
      if (dd[i]) begin
        t1 = mulm(u2, v, n);
        t2 = mulm(u, v2, n);
        t3 = mulm(v2, v, n);
        t4 = mulm(mulm(u2, u, n), dm, n);
        u = halfm(addm(t1, t2, n), n);
        v = halfm(addm(t3, t4, n), n);
        qkd = mulm(qkd, qm, n);
      end
    end
    if (u == 0 || v == 0) return '{1'b1, 32'(d)};
    q2kd = addm(qkd, qkd, n);
    for (int r = 1; r < s; r++) begin
      v = subm(mulm(v, v, n), q2kd, n);
      if (v == 0) return '{1'b1, 32'(d)};
      if (r + 1 < s) begin
        qkd = mulm(qkd, qkd, n);
        q2kd = addm(qkd, qkd, n);
      end
    end
    return '{1'b0, 32'(d)};
  endfunction

  task automatic send_candidate(logic [63:0] cand);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = cand;
    do @(posedge clk); while (!in_tready);
    verdicts_due.push_back(lucas_verdict(cand));
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    go_quiet();
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random idling, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected beat %h", out_tdata);
        errors++;
      end else begin
        exp_v = verdicts_due.pop_front();
        if (out_tdata[0] !== exp_v.prime) begin
          $error("probable_prime expected %0d actual %0d", exp_v.prime, out_tdata[0]);
          errors++;
        end
        if (out_tdata[32:1] !== exp_v.disc) begin
          $error("chosen_d expected %0d actual %0d", exp_v.disc, $signed(out_tdata[32:1]));
          errors++;
        end
        if (out_tdata[39:33] !== 7'd0) begin
          $error("zero expected 0 actual %h", out_tdata[39:33]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] random_candidate();
    logic [63:0] x;
    int pick;
    pick = $urandom_range(99);
    x = {$urandom, $urandom};
    if (pick < 55) return {44'd0, x[19:1], 1'b1};
    if (pick < 65) return {48'd0, x[15:0]};
    if (pick < 75) return {32'd0, x[31:0]};
    if (pick < 82) return 64'(x[15:0]) * 64'(x[15:0]);
    if (pick < 90) return x | 64'd1;
    return x;
  endfunction

  task automatic test_directed();
    logic [63:0] seeds[$];
    seeds = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd15, 64'd21,
              64'd97, 64'd5459, 64'd5777, 64'd10877, 64'd65535, 64'd1000003,
              64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
              64'hFFFF_FFFE_0000_0001, 64'h8000_0000_0000_0000,
              64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB,
              64'd4294967291, 64'd2147483647};
    foreach (seeds[i]) send_candidate(seeds[i]);
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_candidate(random_candidate());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 30000;
    repeat (6) send_candidate({48'd0, 16'($urandom) | 16'd1});
    wait_drained();
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(90, 10, 76);
    test_random(90, 76, 10);
    wait_drained();
    test_backpressure();
    test_random(90, 0, 0);
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
